FILE: rtl/lfr_pkg.sv
package lfr_pkg;

   // Table sizing.
   localparam int TABLE_ENTRIES  = 5;
   localparam int MAX_DATA_BYTES = 8;
   localparam int ENTRY_REGS     = 5;
   localparam int MATCH_ENTRIES  = (TABLE_ENTRIES < ENTRY_REGS) ? TABLE_ENTRIES : ENTRY_REGS;
   localparam int STORE_BYTES    = 8;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_ENTRY_LAST = 3'(ENTRY_REGS - 1);
   localparam logic [2:0] CSR_NODE_ROLE  = 3'(ENTRY_REGS);

   localparam logic [7:0] SYNC_BYTE = 8'h55;

   // Reset contents of the identifier table.
   localparam logic [12:0] ENTRY_RESET [ENTRY_REGS] = '{
      13'd1024, 13'd1360, 13'd2208, 13'd4592, 13'd4156
   };

   // Event kinds.
   localparam logic FUNC_BREAK = 1'b0;
   localparam logic FUNC_BYTE  = 1'b1;

   // Result status codes.
   localparam logic [2:0] ST_IGNORED  = 3'd0;
   localparam logic [2:0] ST_BREAK    = 3'd1;
   localparam logic [2:0] ST_SYNC_OK  = 3'd2;
   localparam logic [2:0] ST_SYNC_BAD = 3'd3;
   localparam logic [2:0] ST_ID_TAKEN = 3'd4;
   localparam logic [2:0] ST_DATA     = 3'd5;
   localparam logic [2:0] ST_COMPLETE = 3'd6;
   localparam logic [2:0] ST_ERROR    = 3'd7;

   // Error kinds.
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNKNOWN_ID = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG   = 2'd2;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  error_kind;
      logic [2:0]  entry_index;
      logic [7:0]  frame_id;
      logic [3:0]  data_count;
      logic [63:0] frame_data;
      logic        frame_accepted;
      logic        response_needed;
   } rsp_type;

endpackage

FILE: rtl/lin_frame_receiver.sv
// LIN frame receiver.
//
// The req channel carries one bus event per item: a break (func low) or a
// received byte (func high, value in rx_byte). Every accepted item produces
// exactly one result item on the rsp channel, carrying the status of that
// event together with the frame state left behind by it.
//
// The result is registered: the result of an item accepted at a clock edge is
// valid after that edge. Throughput is one item per cycle while rsp_ready is
// high; the identifier compare against all table entries and the data store
// update happen in one combinational step from frame state to result register.
//
// While the rsp side stalls, the result register holds its item and
// req_ready drops; an item is taken again in the same cycle the waiting
// result leaves. The csr port writes table entries and the node role; it is
// meant to be used only while no item is in flight.
//
// Reset (synchronous) clears the header flags, frame state and output valid,
// and reloads the default identifier table and the master role.
module lin_frame_receiver (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lfr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lfr_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_addr,
   input  logic [12:0]      csr_wdata
);
   import lfr_pkg::*;

   // Configuration and frame state.
   logic [12:0] entry_ff [ENTRY_REGS];
   logic        master_ff;
   logic        break_ff, break_in;
   logic        sync_ff, sync_in;
   logic        id_ff, id_in;
   logic [2:0]  entry_sel_ff, entry_sel_in;
   logic [7:0]  cur_id_ff, cur_id_in;
   logic [3:0]  count_ff, count_in;
   logic [7:0]  store_ff [STORE_BYTES];
   logic [7:0]  store_in [STORE_BYTES];

   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        accept;
   logic        found;
   logic [2:0]  hit;
   logic [3:0]  raw_len;
   logic [3:0]  len;
   logic        resp_flag;
   logic [3:0]  count_inc;

   // The result register frees up when it is empty or being taken.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // First matching table entry wins, so scan from the top down.
   always_comb begin
      found = 1'b0;
      hit   = '0;
      for (int e = MATCH_ENTRIES - 1; e >= 0; e--) begin
         if (entry_ff[e][7:0] == req_data.rx_byte) begin
            found = 1'b1;
            hit   = 3'(e);
         end
      end
   end

   // Length and response flag of the current frame's entry.
   always_comb begin
      raw_len   = '0;
      resp_flag = 1'b0;
      if (entry_sel_ff < 3'(ENTRY_REGS)) begin
         raw_len   = entry_ff[entry_sel_ff][12:9];
         resp_flag = entry_ff[entry_sel_ff][8];
      end
      len = (raw_len > 4'(MAX_DATA_BYTES)) ? 4'(MAX_DATA_BYTES) : raw_len;
   end

   assign count_inc = count_ff + 4'd1;

   // Frame sequencing for one event.
   always_comb begin
      break_in     = break_ff;
      sync_in      = sync_ff;
      id_in        = id_ff;
      entry_sel_in = entry_sel_ff;
      cur_id_in    = cur_id_ff;
      count_in     = count_ff;
      store_in     = store_ff;
      rsp_in       = '0;
      rsp_in.status     = ST_IGNORED;
      rsp_in.error_kind = ERR_NONE;

      if (req_data.func == FUNC_BREAK) begin
         break_in = 1'b1;
         sync_in  = 1'b0;
         id_in    = 1'b0;
         count_in = '0;
         rsp_in.status = ST_BREAK;
      end else if (break_ff) begin
         break_in = 1'b0;
         sync_in  = (req_data.rx_byte == SYNC_BYTE);
         rsp_in.status = (req_data.rx_byte == SYNC_BYTE) ? ST_SYNC_OK : ST_SYNC_BAD;
      end else if (sync_ff) begin
         sync_in   = 1'b0;
         cur_id_in = req_data.rx_byte;
         count_in  = '0;
         if (found) begin
            id_in        = 1'b1;
            entry_sel_in = hit;
            rsp_in.status = ST_ID_TAKEN;
            rsp_in.response_needed = !master_ff && entry_ff[hit][8];
         end else begin
            break_in     = 1'b0;
            id_in        = 1'b0;
            entry_sel_in = '0;
            rsp_in.status     = ST_ERROR;
            rsp_in.error_kind = ERR_UNKNOWN_ID;
         end
      end else if (id_ff) begin
         if (count_ff < len && count_ff < 4'(STORE_BYTES)) begin
            store_in[count_ff[2:0]] = req_data.rx_byte;
            count_in = count_inc;
            if (count_inc == len) begin
               rsp_in.frame_accepted = master_ff ? resp_flag : !resp_flag;
               break_in = 1'b0;
               sync_in  = 1'b0;
               id_in    = 1'b0;
               rsp_in.status = ST_COMPLETE;
            end else begin
               rsp_in.status = ST_DATA;
            end
         end else begin
            break_in = 1'b0;
            sync_in  = 1'b0;
            id_in    = 1'b0;
            count_in = '0;
            rsp_in.status     = ST_ERROR;
            rsp_in.error_kind = ERR_TOO_LONG;
         end
      end

      rsp_in.entry_index = entry_sel_in;
      rsp_in.frame_id    = cur_id_in;
      rsp_in.data_count  = count_in;
      // Only bytes below the count are shown; the rest read as zero.
      for (int k = 0; k < STORE_BYTES; k++) begin
         rsp_in.frame_data[8*k +: 8] = (4'(k) < count_in) ? store_in[k] : 8'h00;
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < ENTRY_REGS; e++) begin
            entry_ff[e] <= ENTRY_RESET[e];
         end
         master_ff    <= 1'b1;
         break_ff     <= 1'b0;
         sync_ff      <= 1'b0;
         id_ff        <= 1'b0;
         entry_sel_ff <= '0;
         cur_id_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_addr <= CSR_ENTRY_LAST) begin
               entry_ff[csr_addr] <= csr_wdata;
            end else if (csr_addr == CSR_NODE_ROLE) begin
               master_ff <= csr_wdata[0];
            end
         end
         if (accept) begin
            break_ff     <= break_in;
            sync_ff      <= sync_in;
            id_ff        <= id_in;
            entry_sel_ff <= entry_sel_in;
            cur_id_ff    <= cur_id_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: data store and result item.
   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff <= store_in;
         rsp_ff   <= rsp_in;
      end
   end

endmodule

FILE: test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lfr_pkg::*;

   localparam logic [2:0]  CSR_ENTRY_FIRST  = 3'd0;
   localparam logic [2:0]  CSR_FIRST_UNUSED = CSR_NODE_ROLE + 3'd1;
   localparam logic [12:0] WORD_MAX         = 13'h1FFF;
   localparam int          LONG_HOLD        = 40;

   // Tracks the frame state of the receiver and keeps the results still owed by it.
   class lin_frame_tracker;
      logic [12:0] entry_word [ENTRY_REGS];
      logic        is_master;
      bit          break_pending;
      bit          sync_pending;
      bit          in_frame;
      logic [2:0]  cur_entry;
      logic [7:0]  cur_id;
      logic [3:0]  byte_count;
      logic [7:0]  data_bytes [STORE_BYTES];
      rsp_type     awaited [$];
      int          failures;

      function new();
         for (int i = 0; i < ENTRY_REGS; i++) entry_word[i] = ENTRY_RESET[i];
         for (int k = 0; k < STORE_BYTES; k++) data_bytes[k] = '0;
         is_master = 1'b1;
         break_pending = 1'b0;
         sync_pending = 1'b0;
         in_frame = 1'b0;
         cur_entry = '0;
         cur_id = '0;
         byte_count = '0;
         failures = 0;
      endfunction

      function void write_reg(logic [2:0] addr, logic [12:0] value);
         if (addr <= CSR_ENTRY_LAST) begin
            entry_word[addr] = value;
         end else if (addr == CSR_NODE_ROLE) begin
            is_master = value[0];
         end
      endfunction

      // Works out the result of one accepted bus event and queues it.
      function void note_event(req_type ev);
         rsp_type     r;
         int          hit;
         int unsigned len;
         logic        resp;
         r = '0;
         if (ev.func == FUNC_BREAK) begin
            break_pending = 1'b1;
            sync_pending = 1'b0;
            in_frame = 1'b0;
            byte_count = '0;
            r.status = ST_BREAK;
         end else if (break_pending) begin
            break_pending = 1'b0;
            sync_pending = (ev.rx_byte == SYNC_BYTE);
            r.status = sync_pending ? ST_SYNC_OK : ST_SYNC_BAD;
         end else if (sync_pending) begin
            sync_pending = 1'b0;
            // The lowest matching entry wins, so scan downward.
            hit = -1;
            for (int e = MATCH_ENTRIES - 1; e >= 0; e--) begin
               if (entry_word[e][7:0] == ev.rx_byte) hit = e;
            end
            cur_id = ev.rx_byte;
            byte_count = '0;
            if (hit >= 0) begin
               in_frame = 1'b1;
               cur_entry = 3'(hit);
               r.status = ST_ID_TAKEN;
               r.response_needed = !is_master && entry_word[hit][8];
            end else begin
               in_frame = 1'b0;
               cur_entry = '0;
               r.status = ST_ERROR;
               r.error_kind = ERR_UNKNOWN_ID;
            end
         end else if (in_frame) begin
            // Lengths above the store capacity saturate.
            len = entry_word[cur_entry][12:9];
            if (len > MAX_DATA_BYTES) len = MAX_DATA_BYTES;
            if (len > STORE_BYTES) len = STORE_BYTES;
            if (byte_count < len) begin
               data_bytes[byte_count[2:0]] = ev.rx_byte;
               byte_count++;
               if (byte_count == len) begin
                  resp = entry_word[cur_entry][8];
                  r.frame_accepted = is_master ? resp : !resp;
                  in_frame = 1'b0;
                  r.status = ST_COMPLETE;
               end else begin
                  r.status = ST_DATA;
               end
            end else begin
               in_frame = 1'b0;
               byte_count = '0;
               r.status = ST_ERROR;
               r.error_kind = ERR_TOO_LONG;
            end
         end else begin
            r.status = ST_IGNORED;
         end
         r.entry_index = cur_entry;
         r.frame_id = cur_id;
         r.data_count = byte_count;
         for (int k = 0; k < byte_count; k++) r.frame_data[8*k +: 8] = data_bytes[k];
         awaited.push_back(r);
      endfunction

      function void check_field(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s expected %0h got %0h", field, want, got);
            failures++;
         end
      endfunction

      // Compares one result item with the oldest one still owed.
      function void check_rsp(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $error("result item with no event waiting, status %0d", got.status);
            failures++;
            return;
         end
         want = awaited.pop_front();
         check_field("status", want.status, got.status);
         check_field("error_kind", want.error_kind, got.error_kind);
         check_field("entry_index", want.entry_index, got.entry_index);
         check_field("frame_id", want.frame_id, got.frame_id);
         check_field("data_count", want.data_count, got.data_count);
         check_field("frame_data", want.frame_data, got.frame_data);
         check_field("frame_accepted", want.frame_accepted, got.frame_accepted);
         check_field("response_needed", want.response_needed, got.response_needed);
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [12:0] csr_wdata = '0;

   lin_frame_tracker tracker;
   req_type          plan [$];
   logic [12:0]      table_words [ENTRY_REGS];
   int unsigned      send_idle_pct = 29;
   int unsigned      recv_idle_pct = 47;
   bit               long_hold_req = 1'b0;

   lin_frame_receiver dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Hard limit on the run.
   initial begin
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end

   // Result side: random stalls, one long hold-off on request, check on every item.
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req && stall_left == 0) begin
            stall_left = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready) tracker.check_rsp(rsp_data);
      end
   end

   function automatic void add_item(logic func, logic [7:0] value);
      req_type ev;
      ev.func = func;
      ev.rx_byte = value;
      plan.push_back(ev);
   endfunction

   function automatic void add_break();
      add_item(FUNC_BREAK, 8'($urandom));
   endfunction

   function automatic void add_byte(logic [7:0] value);
      add_item(FUNC_BYTE, value);
   endfunction

   // Offers one item, with random idle cycles ahead of it; called at a falling edge.
   task automatic send_event(req_type ev);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= ev;
      do @(posedge clock); while (!req_ready);
      tracker.note_event(ev);
      @(negedge clock);
   endtask

   // Stops offering items and waits until every result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic send_plan(int hold_at, int pause_at);
      for (int j = 0; j < plan.size(); j++) begin
         if (j == hold_at) long_hold_req = 1'b1;
         if (j == pause_at) drain();
         send_event(plan[j]);
      end
      plan.delete();
      drain();
   endtask

   task automatic write_csr(logic [2:0] addr, logic [12:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      tracker.write_reg(addr, value);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Writes the whole table, the role, and junk to the indexes past the role.
   task automatic load_table(logic role);
      for (int i = 0; i < ENTRY_REGS; i++) write_csr(CSR_ENTRY_FIRST + 3'(i), table_words[i]);
      write_csr(CSR_NODE_ROLE, {12'($urandom), role});
      for (int a = CSR_FIRST_UNUSED; a < (1 << $bits(csr_addr)); a++) begin
         write_csr(3'(a), 13'($urandom));
      end
   endtask

   // Mostly well-formed frames with random content, the rest noise and broken headers.
   task automatic build_round(int count);
      int          r;
      int          len;
      int          pick;
      logic [12:0] word;
      while (plan.size() < count) begin
         r = $urandom_range(99);
         if (r < 75) begin
            add_break();
            add_byte(($urandom_range(9) == 0) ? 8'($urandom) : SYNC_BYTE);
            word = tracker.entry_word[$urandom_range(ENTRY_REGS - 1)];
            add_byte(($urandom_range(4) == 0) ? 8'($urandom) : word[7:0]);
            len = (word[12:9] > MAX_DATA_BYTES) ? MAX_DATA_BYTES : word[12:9];
            pick = ($urandom_range(9) < 7) ? len : $urandom_range(len + 2);
            for (int k = 0; k < pick; k++) add_byte(8'($urandom));
         end else if (r < 90) begin
            add_item(1'($urandom_range(1)), 8'($urandom));
         end else begin
            add_break();
            add_byte(8'($urandom));
            add_byte(8'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      logic [7:0] id;
      tracker = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default table, master role: header errors, a break inside a frame, both acceptances.
      add_byte(8'hFF);
      add_break(); add_byte(8'h00);
      add_break(); add_break(); add_byte(SYNC_BYTE); add_byte(8'h50);
      add_byte(8'h00); add_byte(8'hFF);
      add_break(); add_byte(SYNC_BYTE); add_byte(8'h12);
      add_break(); add_byte(SYNC_BYTE); add_byte(8'hF0); add_byte(8'hFF); add_byte(8'h00);
      add_break(); add_byte(SYNC_BYTE); add_byte(8'h00); add_byte(8'hAA); add_byte(8'h55);
      send_plan(-1, -1);

      // Slave role with a zero-length entry, a saturated length, a shadowed duplicate
      // and the sync byte used as an identifier.
      table_words = '{13'h0000, WORD_MAX, {4'd1, 1'b0, 8'hFF}, {4'd1, 1'b0, SYNC_BYTE},
                      {4'd3, 1'b1, 8'h3C}};
      load_table(1'b0);
      add_break(); add_byte(SYNC_BYTE); add_byte(8'h00); add_byte(8'hAA);
      add_break(); add_byte(SYNC_BYTE); add_byte(8'hFF);
      for (int k = 0; k < STORE_BYTES; k++) add_byte((k % 2 == 0) ? 8'hFF : 8'h00);
      add_byte(8'h77);
      add_break(); add_byte(SYNC_BYTE); add_byte(SYNC_BYTE); add_byte(8'h01);
      send_plan(-1, -1);

      // Random rounds, each under a fresh table.
      for (int round = 0; round < 6; round++) begin
         if (round == 2) begin
            send_idle_pct = 47;
            recv_idle_pct = 29;
         end
         if (round == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int i = 0; i < ENTRY_REGS; i++) begin
            case ($urandom_range(3))
               0: id = SYNC_BYTE;
               1: id = table_words[$urandom_range(i)][7:0];
               default: id = 8'($urandom);
            endcase
            if (round == 0) begin
               table_words[i] = (i % 2 == 0) ? WORD_MAX : 13'h0000;
            end else begin
               table_words[i] = {4'($urandom_range(15)), 1'($urandom_range(1)), id};
            end
         end
         load_table((round == 0) ? 1'b1 : (round == 1) ? 1'b0 : 1'($urandom_range(1)));
         build_round(60);
         send_plan((round == 1) ? 20 : -1, (round == 3) ? 30 : -1);
      end

      repeat (4) @(negedge clock);
      if (tracker.failures == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
